// ----- hdl/owm_pkg.sv -----
// Shared types and constants for the one-wire bus master.
package owm_pkg;

    // Command codes carried in the opcode field
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WBIT  = 3'd2;
    localparam logic [2:0] OP_RBIT  = 3'd3;
    localparam logic [2:0] OP_WBYTE = 3'd4;
    localparam logic [2:0] OP_RBYTE = 3'd5;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_RST_LOW   = 3'd1;
    localparam logic [2:0] PH_RST_WAIT  = 3'd2;
    localparam logic [2:0] PH_RST_TAIL  = 3'd3;
    localparam logic [2:0] PH_WR_LOW    = 3'd4;
    localparam logic [2:0] PH_SLOT_TAIL = 3'd5;
    localparam logic [2:0] PH_RD_LOW    = 3'd6;
    localparam logic [2:0] PH_RD_WAIT   = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] REG_WRITE_START   = 3'd3;
    localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [2:0] REG_READ_LOW      = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_READ_TAIL     = 3'd7;

    // Timing registers, in ticks
    typedef struct packed {
        logic [15:0] reset_low_ticks;
        logic [15:0] presence_wait_ticks;
        logic [15:0] reset_tail_ticks;
        logic [15:0] write_start_ticks;
        logic [15:0] write_hold_ticks;
        logic [15:0] read_low_ticks;
        logic [15:0] read_sample_ticks;
        logic [15:0] read_tail_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_ticks:     16'd500,
        presence_wait_ticks: 16'd70,
        reset_tail_ticks:    16'd500,
        write_start_ticks:   16'd10,
        write_hold_ticks:    16'd50,
        read_low_ticks:      16'd5,
        read_sample_ticks:   16'd5,
        read_tail_ticks:     16'd50
    };

    // One result item
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

endpackage

// ----- hdl/one_wire_bus_master.sv -----
// Top level of the one-wire bus master.
// Usage:
//   Input channel (i_in_valid / o_in_stall): one transaction per bus tick,
//   carrying an opcode, a data byte and the sampled line level.
//   Output channel (o_out_valid / i_out_stall): one result per input tick,
//   with the line drive, busy, done, presence, read data and rejected flag.
//   Configuration (i_cfg_valid / o_cfg_ready): eight 16-bit timing registers
//   indexed 0..7; write them only while no operation is running.
// Timing: a tick is registered on acceptance and its result is registered
//   into the result queue when the tick leaves the input register.
//   One tick is accepted every cycle unless o_in_stall is high; the rate is
//   set by the combinational sequencer between input register and queue.
// Stall: the two-entry result queue absorbs a stalled result; once it is
//   full the input register holds and o_in_stall rises.
// Reset: the sequencer returns to idle, presence clears, the queue empties
//   and all timing registers take their default values.
module one_wire_bus_master #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data,
    input  logic        i_line_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_drive_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_presence,
    output logic [7:0]  o_read_data,
    output logic        o_rejected,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic             r_in_valid, n_in_valid;
    logic [2:0]       r_in_opcode;
    logic [7:0]       r_in_data;
    logic             r_in_line;
    logic             accept;
    logic             advance;
    logic             buf_full;
    owm_pkg::t_cfg    cfg;
    owm_pkg::t_result core_res;
    owm_pkg::t_result out_res;

    // Input register handshake
    assign o_in_stall = r_in_valid && buf_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign advance    = r_in_valid && !buf_full;
    assign n_in_valid = accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_opcode <= i_opcode;
            r_in_data   <= i_data;
            r_in_line   <= i_line_level;
        end
    end

    // Configuration is always accepted
    assign o_cfg_ready = 1'b1;

    owm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    owm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_opcode     (r_in_opcode),
        .i_data       (r_in_data),
        .i_line_level (r_in_line),
        .i_cfg        (cfg),
        .o_result     (core_res)
    );

    owm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (core_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_res),
        .o_full  (buf_full)
    );

    assign o_drive_low = out_res.drive_low;
    assign o_busy_res  = out_res.busy_res;
    assign o_done_res  = out_res.done_res;
    assign o_presence  = out_res.presence;
    assign o_read_data = out_res.read_data;
    assign o_rejected  = out_res.rejected;

endmodule

// ----- hdl/owm_cfg.sv -----
// Timing register file written through the configuration port.
module owm_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [2:0]           i_index,
    input  logic [15:0]          i_data,
    output owm_pkg::t_cfg        o_cfg
);

    owm_pkg::t_cfg r_regs;
    owm_pkg::t_cfg n_regs;

    // Register write decode
    always_comb begin
        n_regs = r_regs;
        if (i_wr_en) begin
            unique case (i_index)
                owm_pkg::REG_RESET_LOW:     n_regs.reset_low_ticks     = i_data;
                owm_pkg::REG_PRESENCE_WAIT: n_regs.presence_wait_ticks = i_data;
                owm_pkg::REG_RESET_TAIL:    n_regs.reset_tail_ticks    = i_data;
                owm_pkg::REG_WRITE_START:   n_regs.write_start_ticks   = i_data;
                owm_pkg::REG_WRITE_HOLD:    n_regs.write_hold_ticks    = i_data;
                owm_pkg::REG_READ_LOW:      n_regs.read_low_ticks      = i_data;
                owm_pkg::REG_READ_SAMPLE:   n_regs.read_sample_ticks   = i_data;
                owm_pkg::REG_READ_TAIL:     n_regs.read_tail_ticks     = i_data;
                default:                    n_regs = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= owm_pkg::CFG_RESET;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_cfg = r_regs;

endmodule

// ----- hdl/owm_core.sv -----
// Timed phase sequencer: one tick processed per enabled cycle.
module owm_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [2:0]           i_opcode,
    input  logic [7:0]           i_data,
    input  logic                 i_line_level,
    input  owm_pkg::t_cfg        i_cfg,
    output owm_pkg::t_result     o_result
);

    localparam int LenW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [LenW-1:0] CntMax = LenW'({COUNT_WIDTH{1'b1}});

    logic [2:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [2:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    logic [2:0]             r_op, n_op;
    logic                   r_presence, n_presence;

    logic [2:0]             cur_phase;
    logic [COUNT_WIDTH-1:0] cur_tick;
    logic [2:0]             cur_bit;
    logic [7:0]             cur_shift;
    logic [2:0]             cur_op;
    logic                   is_cmd;
    logic                   writing;
    logic                   byte_op;
    logic [15:0]            len_reg;
    logic [LenW-1:0]        len;
    logic [LenW:0]          tick_inc;
    logic                   last_tick;
    owm_pkg::t_result       res;

    assign is_cmd = (i_opcode >= owm_pkg::OP_RESET) && (i_opcode <= owm_pkg::OP_RBYTE);

    // Command start: the accepting tick is the first tick of the first phase
    always_comb begin
        cur_phase = r_phase;
        cur_tick  = r_tick;
        cur_bit   = r_bit;
        cur_shift = r_shift;
        cur_op    = r_op;
        if (r_phase == owm_pkg::PH_IDLE && is_cmd) begin
            cur_op   = i_opcode;
            cur_tick = '0;
            cur_bit  = '0;
            if (i_opcode == owm_pkg::OP_WBIT) begin
                cur_shift = {7'd0, i_data[0]};
            end else if (i_opcode == owm_pkg::OP_WBYTE) begin
                cur_shift = i_data;
            end else begin
                cur_shift = '0;
            end
            if (i_opcode == owm_pkg::OP_RESET) begin
                cur_phase = owm_pkg::PH_RST_LOW;
            end else if (i_opcode == owm_pkg::OP_WBIT || i_opcode == owm_pkg::OP_WBYTE) begin
                cur_phase = owm_pkg::PH_WR_LOW;
            end else begin
                cur_phase = owm_pkg::PH_RD_LOW;
            end
        end
    end

    assign writing = (cur_op == owm_pkg::OP_WBIT) || (cur_op == owm_pkg::OP_WBYTE);
    assign byte_op = (cur_op == owm_pkg::OP_WBYTE) || (cur_op == owm_pkg::OP_RBYTE);

    // Phase length; zero behaves as one tick, long lengths clip to counter max
    always_comb begin
        unique case (cur_phase)
            owm_pkg::PH_RST_LOW:   len_reg = i_cfg.reset_low_ticks;
            owm_pkg::PH_RST_WAIT:  len_reg = i_cfg.presence_wait_ticks;
            owm_pkg::PH_RST_TAIL:  len_reg = i_cfg.reset_tail_ticks;
            owm_pkg::PH_WR_LOW:    len_reg = i_cfg.write_start_ticks;
            owm_pkg::PH_SLOT_TAIL: len_reg = writing ? i_cfg.write_hold_ticks
                                                     : i_cfg.read_tail_ticks;
            owm_pkg::PH_RD_LOW:    len_reg = i_cfg.read_low_ticks;
            owm_pkg::PH_RD_WAIT:   len_reg = i_cfg.read_sample_ticks;
            default:               len_reg = 16'd1;
        endcase
        len = LenW'(len_reg);
        if (len > CntMax) begin
            len = CntMax;
        end
    end

    assign tick_inc  = {1'b0, LenW'(cur_tick)} + (LenW + 1)'(1);
    assign last_tick = tick_inc >= {1'b0, len};

    // Phase transitions and result
    always_comb begin
        n_phase    = cur_phase;
        n_tick     = cur_tick;
        n_bit      = cur_bit;
        n_shift    = cur_shift;
        n_op       = cur_op;
        n_presence = r_presence;
        res        = '0;

        res.rejected = (r_phase != owm_pkg::PH_IDLE) && is_cmd;

        if (cur_phase != owm_pkg::PH_IDLE) begin
            res.busy_res  = 1'b1;
            res.drive_low = (cur_phase == owm_pkg::PH_RST_LOW) ||
                            (cur_phase == owm_pkg::PH_WR_LOW) ||
                            (cur_phase == owm_pkg::PH_RD_LOW) ||
                            ((cur_phase == owm_pkg::PH_SLOT_TAIL) && writing &&
                             !cur_shift[0]);
            if (last_tick) begin
                n_tick = '0;
                unique case (cur_phase)
                    owm_pkg::PH_RST_LOW: begin
                        n_phase = owm_pkg::PH_RST_WAIT;
                    end
                    owm_pkg::PH_RST_WAIT: begin
                        n_presence = !i_line_level;
                        n_phase    = owm_pkg::PH_RST_TAIL;
                    end
                    owm_pkg::PH_RST_TAIL: begin
                        n_phase      = owm_pkg::PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    owm_pkg::PH_WR_LOW: begin
                        n_phase = owm_pkg::PH_SLOT_TAIL;
                    end
                    owm_pkg::PH_RD_LOW: begin
                        n_phase = owm_pkg::PH_RD_WAIT;
                    end
                    owm_pkg::PH_RD_WAIT: begin
                        // sample the bus; bytes arrive LSB first
                        if (cur_op == owm_pkg::OP_RBYTE) begin
                            n_shift = {i_line_level, cur_shift[7:1]};
                        end else begin
                            n_shift = {7'd0, i_line_level};
                        end
                        n_phase = owm_pkg::PH_SLOT_TAIL;
                    end
                    owm_pkg::PH_SLOT_TAIL: begin
                        if (writing) begin
                            n_shift = {1'b0, cur_shift[7:1]};
                        end
                        if (byte_op && cur_bit != 3'd7) begin
                            n_bit   = cur_bit + 3'd1;
                            n_phase = writing ? owm_pkg::PH_WR_LOW : owm_pkg::PH_RD_LOW;
                        end else begin
                            n_phase      = owm_pkg::PH_IDLE;
                            res.done_res = 1'b1;
                            if (!writing) begin
                                res.read_data = cur_shift;
                            end
                        end
                    end
                    default: begin
                        n_phase = owm_pkg::PH_IDLE;
                    end
                endcase
            end else begin
                n_tick = cur_tick + COUNT_WIDTH'(1);
            end
        end
        res.presence = n_presence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= owm_pkg::PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_op       <= owm_pkg::OP_NONE;
            r_presence <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_op       <= n_op;
            r_presence <= n_presence;
        end
    end

    assign o_result = res;

endmodule

// ----- hdl/owm_out_buf.sv -----
// Two-entry result queue: two storage entries addressed by write and read pointers.
module owm_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  owm_pkg::t_result     i_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output owm_pkg::t_result     o_data,
    output logic                 o_full
);

    owm_pkg::t_result r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             pop;

    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/owm_checker.sv -----
// Port-level checks for the one-wire bus master, bound to the top level.
module owm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_drive_low,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic        o_presence,
    input logic [7:0]  o_read_data,
    input logic        o_rejected
);

    // Line is only pulled low during an operation
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_busy_res)
        else $error("line driven low outside an operation");

    // Done and rejected only on ticks that belong to an operation
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_done_res || o_rejected) |-> o_busy_res)
        else $error("done or rejected on an idle tick");

    // Read data appears only on the final tick of an operation
    a_rdata_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_data != 8'd0) |-> o_done_res)
        else $error("read data outside a done tick");

    // A stalled result is held unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive_low) &&
        $stable(o_busy_res) && $stable(o_done_res) && $stable(o_presence) &&
        $stable(o_read_data) && $stable(o_rejected))
        else $error("stalled result changed");

    // Input only stalls while results are waiting on the output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (.*);
